>>> rtl/compacting_tag_queue_defines.svh
// Assertion macros used by the compacting tag queue datapath.
`ifndef COMPACTING_TAG_QUEUE_DEFINES_SVH
`define COMPACTING_TAG_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during reset.
`define CTQ_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk and disabled during reset.
`define CTQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CTQ_ASSERT(label, ante, cons, msg)
`define CTQ_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/ctq_pkg.sv
// Package with the shared types and constants of the compacting tag queue.
package ctq_pkg;

    localparam int DEPTH_DEF    = 32;
    localparam int TAG_BITS_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_FIND   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPORT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
    } dp_status_t;

endpackage

>>> rtl/compacting_tag_queue.sv
// Top level of the compacting tag queue: controller, datapath and tag RAM.
// Enqueue and dequeue pass from idle to the report state, whose commit is registered into done.
// Remove and find walk the stored tags through the single RAM read port, which has registered
// read data: one stored tag is read and compared per cycle until all have been read.
// The result is shown for one cycle with done; the receiver cannot stall, so none is held back.
// Reset (rst_n low, asynchronous) empties the queue; stored tags are not cleared.
module compacting_tag_queue #(
    parameter int DEPTH    = ctq_pkg::DEPTH_DEF,
    parameter int TAG_BITS = ctq_pkg::TAG_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [ctq_pkg::CMD_W-1:0]        cmd,
    input  logic [ctq_pkg::TAG_W-1:0]        tag,
    output logic                             done,
    output logic [ctq_pkg::STATUS_W-1:0]     status,
    output logic [ctq_pkg::POS_W-1:0]        position,
    output logic [ctq_pkg::POS_W-1:0]        count,
    output logic                             is_empty,
    output logic                             is_full
);

    import ctq_pkg::*;

    // The controller sequences each request: a request is taken when start is high and
    // busy is low, walks the stored tags for remove and find, and then commits once.
    ctrl_cmd_t  ctl;
    dp_status_t sts;

    ctq_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .cmd  (cmd),
        .sts  (sts),
        .busy (busy),
        .done (done),
        .ctl  (ctl)
    );

    // The datapath keeps the queue as a ring in RAM with a head pointer, so dequeue only
    // moves the head. Remove copies every non-matching tag down behind the read pointer,
    // which keeps the survivors in order; find records the first matching position.
    ctq_dp #(
        .DEPTH   (DEPTH),
        .TAG_BITS(TAG_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .tag     (tag),
        .ctl     (ctl),
        .sts     (sts),
        .status  (status),
        .position(position),
        .count   (count),
        .is_empty(is_empty),
        .is_full (is_full)
    );

endmodule

>>> rtl/ctq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ctq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/ctq_ctrl.sv
// Controller state machine of the compacting tag queue.
module ctq_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ctq_pkg::CMD_W-1:0]     cmd,
    input  ctq_pkg::dp_status_t           sts,
    output logic                          busy,
    output logic                          done,
    output ctq_pkg::ctrl_cmd_t            ctl
);

    import ctq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        done_reg;
    cmd_t        cmd_in;

    assign cmd_in = cmd_t'(cmd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ctl.commit;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd_in inside {CMD_REMOVE, CMD_FIND})
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_REPORT;
                    end
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        ctl  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                ctl.load = start;
            end
            ST_SCAN:
            begin
                ctl.scan = 1'b1;
            end
            ST_REPORT:
            begin
                ctl.commit = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign done = done_reg;

endmodule

>>> rtl/ctq_dp.sv
// Datapath of the compacting tag queue: ring storage, scan pointers and results.
`include "compacting_tag_queue_defines.svh"

module ctq_dp #(
    parameter int DEPTH    = ctq_pkg::DEPTH_DEF,
    parameter int TAG_BITS = ctq_pkg::TAG_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [ctq_pkg::CMD_W-1:0]        cmd,
    input  logic [ctq_pkg::TAG_W-1:0]        tag,
    input  ctq_pkg::ctrl_cmd_t               ctl,
    output ctq_pkg::dp_status_t              sts,
    output logic [ctq_pkg::STATUS_W-1:0]     status,
    output logic [ctq_pkg::POS_W-1:0]        position,
    output logic [ctq_pkg::POS_W-1:0]        count,
    output logic                             is_empty,
    output logic                             is_full
);

    import ctq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

    // Request and queue state.
    cmd_t                cmd_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [PTR_W-1:0]    head_reg;
    logic [CNT_W-1:0]    fill_reg;

    // Scan state.
    logic [CNT_W-1:0]    rd_idx_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic                cmp_vld_reg;
    logic [CNT_W-1:0]    cmp_pos_reg;
    logic [CNT_W-1:0]    kept_reg;
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [CNT_W-1:0]    pos_reg;

    // Result registers.
    stat_t               status_reg;
    logic [POS_W-1:0]    position_reg;
    logic [POS_W-1:0]    count_reg;
    logic                is_empty_reg;
    logic                is_full_reg;

    logic [TAG_BITS-1:0] rdata;
    logic                rd_en;
    logic                proc;
    logic                is_match;
    logic                remove_wr;
    logic                enq_wr;
    logic                q_full;
    logic                q_empty;
    logic [SUM_W-1:0]    tail_sum;
    logic [PTR_W-1:0]    tail_ptr;
    logic [PTR_W-1:0]    rd_ptr_inc;
    logic [PTR_W-1:0]    wr_ptr_inc;
    logic [PTR_W-1:0]    head_inc;
    logic                ram_we;
    logic [PTR_W-1:0]    ram_waddr;
    logic [TAG_BITS-1:0] ram_wdata;
    logic [CNT_W-1:0]    fill_new;
    stat_t               status_new;

    assign q_full  = (fill_reg == FULL_CNT);
    assign q_empty = (fill_reg == '0);

    assign rd_ptr_inc = (rd_ptr_reg == LAST_PTR) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
    assign wr_ptr_inc = (wr_ptr_reg == LAST_PTR) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
    assign head_inc   = (head_reg == LAST_PTR) ? '0 : PTR_W'(head_reg + 1'b1);

    // The back of the ring is head + fill, wrapped once.
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign tail_ptr = (tail_sum >= DEPTH_SUM) ? PTR_W'(tail_sum - DEPTH_SUM)
                                              : PTR_W'(tail_sum);

    assign rd_en     = ctl.scan && (rd_idx_reg != fill_reg);
    assign proc      = ctl.scan && cmp_vld_reg;
    assign is_match  = (rdata == tag_reg);
    assign remove_wr = proc && (cmd_reg == CMD_REMOVE) && !is_match;
    assign enq_wr    = ctl.commit && (cmd_reg == CMD_ENQ) && !q_full;

    assign sts.scan_done = (rd_idx_reg == fill_reg) && !cmp_vld_reg;

    // Kept entries move down behind the read pointer, or a new tag goes at the back.
    assign ram_we    = remove_wr || enq_wr;
    assign ram_waddr = enq_wr ? tail_ptr : wr_ptr_reg;
    assign ram_wdata = enq_wr ? tag_reg : rdata;

    ctq_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (DEPTH),
        .ADDR_W(PTR_W)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (rd_en),
        .raddr(rd_ptr_reg),
        .rdata(rdata)
    );

    // Effect of the request on the fill count and its status.
    always_comb
    begin
        fill_new   = fill_reg;
        status_new = STAT_DONE;
        case (cmd_reg)
            CMD_ENQ:
            begin
                if (q_full)
                begin
                    status_new = STAT_FULL;
                end
                else
                begin
                    fill_new = CNT_W'(fill_reg + 1'b1);
                end
            end
            CMD_DEQ:
            begin
                if (q_empty)
                begin
                    status_new = STAT_EMPTY;
                end
                else
                begin
                    fill_new = CNT_W'(fill_reg - 1'b1);
                end
            end
            CMD_REMOVE:
            begin
                fill_new = kept_reg;
            end
            default:
            begin
                fill_new = fill_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg     <= CMD_ENQ;
            head_reg    <= '0;
            fill_reg    <= '0;
            rd_idx_reg  <= '0;
            rd_ptr_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            cmp_pos_reg <= '0;
            kept_reg    <= '0;
            wr_ptr_reg  <= '0;
            pos_reg     <= '0;
        end
        else
        begin
            if (ctl.load)
            begin
                cmd_reg     <= cmd_t'(cmd);
                rd_idx_reg  <= '0;
                rd_ptr_reg  <= head_reg;
                cmp_vld_reg <= 1'b0;
                kept_reg    <= '0;
                wr_ptr_reg  <= head_reg;
                pos_reg     <= '0;
            end
            if (ctl.scan)
            begin
                cmp_vld_reg <= rd_en;
                if (rd_en)
                begin
                    rd_idx_reg  <= CNT_W'(rd_idx_reg + 1'b1);
                    rd_ptr_reg  <= rd_ptr_inc;
                    cmp_pos_reg <= CNT_W'(rd_idx_reg + 1'b1);
                end
                if (remove_wr)
                begin
                    kept_reg   <= CNT_W'(kept_reg + 1'b1);
                    wr_ptr_reg <= wr_ptr_inc;
                end
                if (proc && (cmd_reg == CMD_FIND) && is_match && (pos_reg == '0))
                begin
                    pos_reg <= cmp_pos_reg;
                end
            end
            if (ctl.commit)
            begin
                fill_reg <= fill_new;
                if ((cmd_reg == CMD_DEQ) && !q_empty)
                begin
                    head_reg <= head_inc;
                end
            end
        end
    end

    // The tag is taken modulo 2^TAG_BITS.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            tag_reg <= TAG_BITS'(tag);
        end
        if (ctl.commit)
        begin
            status_reg   <= status_new;
            position_reg <= (cmd_reg == CMD_FIND) ? POS_W'(pos_reg) : '0;
            count_reg    <= POS_W'(fill_new);
            is_empty_reg <= (fill_new == '0);
            is_full_reg  <= (fill_new == FULL_CNT);
        end
    end

    assign status   = status_reg;
    assign position = position_reg;
    assign count    = count_reg;
    assign is_empty = is_empty_reg;
    assign is_full  = is_full_reg;

    `CTQ_ASSERT(a_fill_bound, 1'b1, fill_reg <= FULL_CNT, "fill count exceeds depth")
    `CTQ_ASSERT(a_kept_behind, ctl.scan, kept_reg <= rd_idx_reg, "compaction overtook reads")
    `CTQ_ASSERT(a_no_rw_clash, rd_en && ram_we, ram_waddr != rd_ptr_reg, "scan write hit read")
    `CTQ_ASSERT_NXT(a_fill_scan, ctl.scan, $stable(fill_reg), "fill changed during scan")

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the compacting tag queue: a shadow-queue scoreboard and stimulus.
module tb;
    import ctq_pkg::*;

    // One result as it appears on the result ports during the done cycle.
    typedef struct packed {
        stat_t              status;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   count;
        logic               is_empty;
        logic               is_full;
    } response_t;

    // The scoreboard keeps its own ordered copy of the stored tags. Every accepted
    // request is applied to that copy at once, and the response it must produce is
    // queued. The block answers in request order, one response per request, so each
    // strobed result is checked against the oldest queued response.
    class tag_queue_scoreboard;
        logic [TAG_W-1:0] held_tags[$];
        response_t        expected_q[$];
        int               errors;
        int               results_checked;
        int               cmd_seen[4];
        int               full_rejects;
        int               empty_rejects;
        int               peak_fill;

        function int held();
            return held_tags.size();
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(cmd_t c, logic [TAG_W-1:0] t);
            response_t        r;
            logic [TAG_W-1:0] kept[$];
            r.status   = STAT_DONE;
            r.position = '0;
            cmd_seen[int'(c)]++;
            case (c)
                CMD_ENQ:
                begin
                    if (held_tags.size() >= DEPTH_DEF)
                    begin
                        r.status = STAT_FULL;
                        full_rejects++;
                    end
                    else
                        held_tags.push_back(t);
                end
                CMD_DEQ:
                begin
                    if (held_tags.size() == 0)
                    begin
                        r.status = STAT_EMPTY;
                        empty_rejects++;
                    end
                    else
                        void'(held_tags.pop_front());
                end
                CMD_REMOVE:
                begin
                    // Every match goes; the survivors keep their order.
                    foreach (held_tags[i])
                        if (held_tags[i] != t)
                            kept.push_back(held_tags[i]);
                    held_tags = kept;
                end
                default:
                begin
                    for (int i = 0; i < held_tags.size(); i++)
                        if (held_tags[i] == t)
                        begin
                            r.position = POS_W'(i + 1);
                            break;
                        end
                end
            endcase
            r.count    = POS_W'(held_tags.size());
            r.is_empty = (held_tags.size() == 0);
            r.is_full  = (held_tags.size() >= DEPTH_DEF);
            if (held_tags.size() > peak_fill)
                peak_fill = held_tags.size();
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_response(response_t got);
            response_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with no request waiting, status %0d count %0d",
                         $time, got.status, got.count);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            compare_field("status", want.status, got.status);
            compare_field("position", want.position, got.position);
            compare_field("count", want.count, got.count);
            compare_field("is_empty", want.is_empty, got.is_empty);
            compare_field("is_full", want.is_full, got.is_full);
        endfunction
    endclass

    localparam int ITEMS = 700;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [CMD_W-1:0]   cmd;
    logic [TAG_W-1:0]   tag;
    logic               done;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   count;
    logic               is_empty;
    logic               is_full;

    tag_queue_scoreboard sb;
    logic [TAG_W-1:0]    tag_pool[6];
    logic [TAG_W-1:0]    last_tag;
    int                  issued;
    bit                  steady;

    compacting_tag_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .tag      (tag),
        .done     (done),
        .status   (status),
        .position (position),
        .count    (count),
        .is_empty (is_empty),
        .is_full  (is_full)
    );

    initial
        clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Results cannot be held off, so every strobe is checked on the edge that ends it.
    // Values read here are those from before the edge, since the block updates them
    // with nonblocking assignments.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_response({stat_t'(status), position, count, is_empty, is_full});
    end

    // Drives one request. It is entered at a falling edge and leaves at a falling edge.
    // Outside the steady stretch the sender sometimes idles first, leaving start low
    // between requests. A request is taken at the rising edge where start is high
    // and busy is low; only then does the scoreboard learn of it.
    task automatic issue(input cmd_t c, input logic [TAG_W-1:0] t);
        if (!steady && $urandom_range(0, 99) < 18)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        tag   <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(c, t);
        issued++;
        steady = (issued >= 300 && issued < 420);
        @(negedge clk);
    endtask

    // Holds the sender off until every queued response has been seen.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() > 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Mostly tags from a small pool, so that finds hit and removes take out duplicates;
    // the rest are fully random, single-bit or single-cleared-bit patterns that move every tag bit.
    function automatic logic [TAG_W-1:0] pick_tag();
        int               roll;
        logic [TAG_W-1:0] one_hot;
        roll    = $urandom_range(0, 99);
        one_hot = TAG_W'(1) << $urandom_range(0, TAG_W - 1);
        if (roll < 70)
            return tag_pool[$urandom_range(0, 5)];
        else if (roll < 85)
            return TAG_W'($urandom);
        else if (roll < 92)
            return one_hot;
        else
            return ~one_hot;
    endfunction

    // Enqueues until the queue is full, pushes once or twice more to be refused, and
    // looks up the last tag, which then often sits at the very back.
    task automatic fill_to_full();
        while (sb.held() < DEPTH_DEF)
        begin
            last_tag = pick_tag();
            issue(CMD_ENQ, last_tag);
        end
        repeat ($urandom_range(1, 2)) issue(CMD_ENQ, pick_tag());
        issue(CMD_FIND, last_tag);
    endtask

    // Dequeues down to empty and then once or twice into an empty queue.
    task automatic drain_to_empty();
        while (sb.held() > 0)
            issue(CMD_DEQ, pick_tag());
        repeat ($urandom_range(1, 2)) issue(CMD_DEQ, pick_tag());
    endtask

    // A short run of mixed commands, weighted toward growth and lookups.
    task automatic mixed_run();
        int   roll;
        cmd_t c;
        repeat ($urandom_range(4, 12))
        begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
                c = CMD_ENQ;
            else if (roll < 55)
                c = CMD_DEQ;
            else if (roll < 70)
                c = CMD_REMOVE;
            else
                c = CMD_FIND;
            issue(c, pick_tag());
        end
    endtask

    // Stimulus: a directed pass over the empty-queue cases, duplicates and lookups, a
    // first fill to full, then random episodes until the item budget is used.
    initial
    begin
        int episode;
        int mode;
        sb      = new();
        rst_n   = 1'b0;
        start   = 1'b0;
        cmd     = CMD_ENQ;
        tag     = '0;
        issued  = 0;
        steady  = 1'b0;
        episode = 0;
        foreach (tag_pool[i])
            tag_pool[i] = TAG_W'($urandom);
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Dequeue, find and remove on an empty queue.
        issue(CMD_DEQ, 16'h0000);
        issue(CMD_FIND, 16'h1234);
        issue(CMD_REMOVE, 16'h1234);
        // Extreme and alternating tags, with one duplicate.
        issue(CMD_ENQ, 16'h0000);
        issue(CMD_ENQ, 16'hFFFF);
        issue(CMD_ENQ, 16'hAAAA);
        issue(CMD_ENQ, 16'h5555);
        issue(CMD_ENQ, 16'hFFFF);
        issue(CMD_FIND, 16'hFFFF);
        issue(CMD_FIND, 16'h5555);
        issue(CMD_FIND, 16'h1234);
        // Removing a duplicated tag takes both copies; a missing tag changes nothing.
        issue(CMD_REMOVE, 16'hFFFF);
        issue(CMD_REMOVE, 16'h7777);
        issue(CMD_DEQ, 16'h0000);
        issue(CMD_FIND, 16'hAAAA);
        issue(CMD_DEQ, 16'h0000);
        issue(CMD_DEQ, 16'h0000);
        issue(CMD_DEQ, 16'h0000);
        drain();

        fill_to_full();
        issue(CMD_REMOVE, tag_pool[0]);
        drain();

        while (issued < ITEMS)
        begin
            episode++;
            mode = $urandom_range(0, 9);
            if (mode < 2)
                fill_to_full();
            else if (mode < 3)
                drain_to_empty();
            else if (mode < 4)
                issue(CMD_REMOVE, tag_pool[$urandom_range(0, 5)]);
            else
                mixed_run();
            if (episode == 25)
                drain();
        end

        // A remove or find on a full queue is the longest request.
        start <= 1'b0;
        while (sb.pending() > 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("tb: %0d transfers (enqueue %0d, dequeue %0d, remove %0d, find %0d), %0d results",
                 issued, sb.cmd_seen[CMD_ENQ], sb.cmd_seen[CMD_DEQ], sb.cmd_seen[CMD_REMOVE],
                 sb.cmd_seen[CMD_FIND], sb.results_checked);
        $display("tb: %0d refused when full, %0d refused when empty, peak occupancy %0d",
                 sb.full_rejects, sb.empty_rejects, sb.peak_fill);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #400000;
        $display("tb: errors");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/ctq_pkg.sv
rtl/ctq_ram.sv
rtl/ctq_ctrl.sv
rtl/ctq_dp.sv
rtl/compacting_tag_queue.sv
tb/sv/tb.sv
